// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/mwf_pkg.sv
// Package with shared constants and codes of the RGB window median filter.
package mwf_pkg;

  localparam int DEF_WINDOW    = 3;
  localparam int DEF_MAX_WIDTH = 1024;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int CFG_DATA_W = 16;

  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 768;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_t;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

// File: rtl/core/median_window_filter_rgb.sv
// Top level of the streaming RGB window median filter with its line store.
//
// Pixels enter in raster order on the in_ channel (tuser = 0) and each lane
// of the result on the out_ channel is the median of the WINDOW x WINDOW
// neighborhood of one pixel, with edge pixels replicated outside the frame.
// A result leaves as soon as all its neighbors have arrived; an input item
// releases at most two results, and drain items (tuser = 1) release the
// remaining results of a frame one per transfer. tlast marks the final result
// of an input item and tuser marks the frame's last pixel.
// Image size is written through the cfg_ port, by the user only while the
// block is idle; the block does not enforce this. Any write restarts the
// frame. A pixel after a completed frame starts a new one. Throughput is one
// item per cycle while the result queue has room. Each result takes one read
// of the single read port of the line store, and the first result of each row
// costs 2*(WINDOW/2) extra reads to fill the window, so items stall briefly at
// row starts. A result passes from the queue through the line store read and
// the window, rank-select and output registers. Reset clears positions, pending
// results and the window; the line store is not cleared. A result waiting at
// the output holds the pipeline; in_tready drops once three results are queued.
module median_window_filter_rgb
  import mwf_pkg::*;
#(
  parameter int WINDOW    = DEF_WINDOW,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic [0:0]            in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // median_red, median_green, median_blue
  output logic                  out_tlast,
  output logic [0:0]            out_tuser,  // frame_end
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int R     = WINDOW / 2;
  localparam int TAPS  = WINDOW * WINDOW;
  localparam int MID   = TAPS / 2;
  localparam int SLOTS = 2 * WINDOW + 8;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int XW    = CW + 2;
  localparam int FD    = 4;
  localparam int FPW   = $clog2(FD);
  localparam int FCW   = FPW + 1;
  localparam int STW   = $clog2(2 * R + 1);
  localparam int CNTW  = $clog2(TAPS + 1);
  localparam int RST_EFF_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  typedef struct packed {
    logic [CW-1:0]      ox;
    logic [IMG_H_W-1:0] oy;
    logic [SW-1:0]      slot;
  } pos_t;

  typedef struct packed {
    pos_t pos;
    logic last;
    logic fend;
  } job_t;

  logic [WW-1:0]      eff_w_r;
  logic [IMG_H_W-1:0] eff_h_r;
  logic [CW-1:0]      col_r, col_nxt;
  logic [IMG_H_W-1:0] row_r, row_nxt;
  logic               done_r, done_nxt;
  logic [SW-1:0]      wr_slot_r, wr_slot_nxt;
  pos_t               cur_r, pos_nxt;
  logic [IMG_H_W-1:0] hm1;
  logic [CW-1:0]      wm1;

  job_t               fifo_r [FD];
  logic [FPW-1:0]     wp_r, rp_r;
  logic [FCW-1:0]     cnt_r;

  logic               acc, pix;
  pos_t               p0, p1, p2;
  logic               r0, r1;
  job_t               j0, j1;

  logic [SLOTS-1:0][PIX_W-1:0] mem [MAX_WIDTH];
  logic [SLOTS-1:0][PIX_W-1:0] rd_r;

  logic               adv, have, issue, pop, is_last_step;
  job_t               head;
  logic [STW-1:0]     step_r, step_cur;
  logic [CW-1:0]      col_addr;
  logic [SW-1:0]      slot_sel [WINDOW];

  logic               s1_v_r, s1_end_r, s1_last_r, s1_fend_r;
  logic [SW-1:0]      s1_slot_r [WINDOW];
  logic [PIX_W-1:0]   win_r [WINDOW][WINDOW];
  logic               s2_v_r, s2_last_r, s2_fend_r;
  logic [PIX_W-1:0]   taps [TAPS];
  logic [TAPS-1:0]    sel_nxt [3];
  logic               s3_v_r, s3_last_r, s3_fend_r;
  logic [TAPS-1:0]    sel_r [3];
  logic [PIX_W-1:0]   v3_r [TAPS];
  logic [PIX_W-1:0]   med;

  logic               out_valid_r, out_last_r, out_fend_r;
  logic [PIX_W-1:0]   out_data_r;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(SLOTS - 1)) ? '0 : s + SW'(1);
  endfunction

  function automatic pos_t pos_succ(input pos_t p, input logic [WW-1:0] w);
    pos_t q;
    q = p;
    if (WW'(p.ox) + WW'(1) == w) begin
      q.ox   = '0;
      q.oy   = p.oy + IMG_H_W'(1);
      q.slot = slot_inc(p.slot);
    end else begin
      q.ox = p.ox + CW'(1);
    end
    return q;
  endfunction

  function automatic logic pos_ready(input pos_t p, input logic [IMG_H_W-1:0] row,
                                     input logic [CW-1:0] col, input logic done,
                                     input logic [CW-1:0] wl, input logic [IMG_H_W-1:0] hl,
                                     input logic [IMG_H_W-1:0] h);
    logic [IMG_H_W:0]   ny_s;
    logic [IMG_H_W-1:0] ny;
    logic [XW-1:0]      nx_s;
    logic [CW-1:0]      nx;
    ny_s = (IMG_H_W + 1)'(p.oy) + (IMG_H_W + 1)'(R);
    ny   = (ny_s > (IMG_H_W + 1)'(hl)) ? hl : ny_s[IMG_H_W-1:0];
    nx_s = XW'(p.ox) + XW'(R);
    nx   = (nx_s > XW'(wl)) ? wl : nx_s[CW-1:0];
    return (p.oy < h) && (done || (ny < row) || ((ny == row) && (nx < col)));
  endfunction

  assign hm1 = eff_h_r - IMG_H_W'(1);
  assign wm1 = CW'(eff_w_r - WW'(1));

  assign in_tready = (cnt_r <= FCW'(FD - 2));
  assign acc       = in_tvalid && in_tready;
  assign pix       = acc && (action_t'(in_tuser[0]) == ACT_PIXEL);

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    done_nxt    = done_r;
    wr_slot_nxt = wr_slot_r;
    p0          = cur_r;
    if (pix) begin
      if (done_r) begin
        p0 = '{ox: '0, oy: '0, slot: wr_slot_r};
      end
      if (WW'(col_r) + WW'(1) == eff_w_r) begin
        col_nxt     = '0;
        wr_slot_nxt = slot_inc(wr_slot_r);
        if ((IMG_H_W + 1)'(row_r) + (IMG_H_W + 1)'(1) == (IMG_H_W + 1)'(eff_h_r)) begin
          row_nxt  = '0;
          done_nxt = 1'b1;
        end else begin
          row_nxt  = row_r + IMG_H_W'(1);
          done_nxt = 1'b0;
        end
      end else begin
        col_nxt  = col_r + CW'(1);
        done_nxt = 1'b0;
      end
    end
    p1 = pos_succ(p0, eff_w_r);
    p2 = pos_succ(p1, eff_w_r);
    r0 = acc && pos_ready(p0, row_nxt, col_nxt, done_nxt, wm1, hm1, eff_h_r);
    r1 = pix && r0 && pos_ready(p1, row_nxt, col_nxt, done_nxt, wm1, hm1, eff_h_r);
    if (!acc) begin
      pos_nxt = cur_r;
    end else if (r1) begin
      pos_nxt = p2;
    end else if (r0) begin
      pos_nxt = p1;
    end else begin
      pos_nxt = p0;
    end
    j0 = '{pos: p0, last: !r1, fend: (p0.oy == hm1) && (p0.ox == wm1)};
    j1 = '{pos: p1, last: 1'b1, fend: (p1.oy == hm1) && (p1.ox == wm1)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r   <= WW'(RST_EFF_W);
      eff_h_r   <= IMG_H_W'(RESET_HEIGHT);
      col_r     <= '0;
      row_r     <= '0;
      done_r    <= 1'b0;
      wr_slot_r <= '0;
      cur_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH: begin
          if (cfg_data[IMG_W_W-1:0] == '0) begin
            eff_w_r <= WW'(1);
          end else if (XW'(cfg_data[IMG_W_W-1:0]) > XW'(MAX_WIDTH)) begin
            eff_w_r <= WW'(MAX_WIDTH);
          end else begin
            eff_w_r <= WW'(cfg_data[IMG_W_W-1:0]);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          eff_h_r <= (cfg_data == '0) ? IMG_H_W'(1) : cfg_data;
        end
        default: begin
          eff_h_r <= eff_h_r;
        end
      endcase
      col_r     <= '0;
      row_r     <= '0;
      done_r    <= 1'b0;
      wr_slot_r <= '0;
      cur_r     <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      done_r    <= done_nxt;
      wr_slot_r <= wr_slot_nxt;
      cur_r     <= pos_nxt;
    end
  end

  assign have         = (cnt_r != '0);
  assign head         = fifo_r[rp_r];
  assign adv          = !out_valid_r || out_tready;
  assign step_cur     = (head.pos.ox == '0) ? step_r : STW'(2 * R);
  assign is_last_step = (step_cur == STW'(2 * R));
  assign issue        = adv && have;
  assign pop          = issue && is_last_step;

  always_comb begin
    logic [XW-1:0]      t;
    logic [XW-1:0]      cu;
    logic [IMG_H_W:0]   k17;
    logic [SW+1:0]      sum;
    t        = XW'(head.pos.ox) + XW'(step_cur);
    cu       = (t < XW'(R)) ? '0 : t - XW'(R);
    col_addr = (cu > XW'(wm1)) ? wm1 : cu[CW-1:0];
    for (int d = 0; d < WINDOW; d++) begin
      if ((IMG_H_W + 1)'(head.pos.oy) + (IMG_H_W + 1)'(d) < (IMG_H_W + 1)'(R)) begin
        k17 = (IMG_H_W + 1)'(R) - (IMG_H_W + 1)'(head.pos.oy);
      end else if ((IMG_H_W + 1)'(head.pos.oy) + (IMG_H_W + 1)'(d) >
                   (IMG_H_W + 1)'(hm1) + (IMG_H_W + 1)'(R)) begin
        k17 = (IMG_H_W + 1)'(hm1) + (IMG_H_W + 1)'(R) - (IMG_H_W + 1)'(head.pos.oy);
      end else begin
        k17 = (IMG_H_W + 1)'(d);
      end
      sum = (SW + 2)'(head.pos.slot) + (SW + 2)'(SLOTS - R) + (SW + 2)'(k17);
      if (sum >= (SW + 2)'(2 * SLOTS)) begin
        sum = sum - (SW + 2)'(2 * SLOTS);
      end else if (sum >= (SW + 2)'(SLOTS)) begin
        sum = sum - (SW + 2)'(SLOTS);
      end
      slot_sel[d] = sum[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      step_r <= '0;
    end else begin
      if (r0) begin
        fifo_r[wp_r] <= j0;
      end
      if (r1) begin
        fifo_r[wp_r + FPW'(1)] <= j1;
      end
      wp_r  <= wp_r + FPW'(r0) + FPW'(r1);
      rp_r  <= rp_r + FPW'(pop);
      cnt_r <= cnt_r + FCW'(r0) + FCW'(r1) - FCW'(pop);
      if (issue) begin
        step_r <= is_last_step ? '0 : step_r + STW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix) begin
      mem[col_r][wr_slot_r] <= in_tdata;
    end
    if (issue) begin
      rd_r <= mem[col_addr];
    end
  end

  always_comb begin
    logic [CNTW-1:0] lt;
    logic [CNTW-1:0] le;
    for (int d = 0; d < WINDOW; d++) begin
      for (int k = 0; k < WINDOW; k++) begin
        taps[d * WINDOW + k] = win_r[d][k];
      end
    end
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < TAPS; i++) begin
        lt = '0;
        le = '0;
        for (int j = 0; j < TAPS; j++) begin
          if (taps[j][CH_W*c +: CH_W] < taps[i][CH_W*c +: CH_W]) begin
            lt = lt + CNTW'(1);
          end
          if (taps[j][CH_W*c +: CH_W] <= taps[i][CH_W*c +: CH_W]) begin
            le = le + CNTW'(1);
          end
        end
        sel_nxt[c][i] = (lt <= CNTW'(MID)) && (le > CNTW'(MID));
      end
    end
  end

  always_comb begin
    med = '0;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < TAPS; i++) begin
        if (sel_r[c][i]) begin
          med[CH_W*c +: CH_W] = med[CH_W*c +: CH_W] | v3_r[i][CH_W*c +: CH_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int d = 0; d < WINDOW; d++) begin
        for (int k = 0; k < WINDOW; k++) begin
          win_r[d][k] <= '0;
        end
      end
    end else if (adv) begin
      s1_v_r    <= issue;
      s1_end_r  <= is_last_step;
      s1_last_r <= head.last;
      s1_fend_r <= head.fend;
      for (int d = 0; d < WINDOW; d++) begin
        s1_slot_r[d] <= slot_sel[d];
      end
      if (s1_v_r) begin
        for (int d = 0; d < WINDOW; d++) begin
          for (int k = 0; k < WINDOW - 1; k++) begin
            win_r[d][k] <= win_r[d][k+1];
          end
          win_r[d][WINDOW-1] <= rd_r[s1_slot_r[d]];
        end
      end
      s2_v_r    <= s1_v_r && s1_end_r;
      s2_last_r <= s1_last_r;
      s2_fend_r <= s1_fend_r;
      s3_v_r    <= s2_v_r;
      s3_last_r <= s2_last_r;
      s3_fend_r <= s2_fend_r;
      for (int c = 0; c < 3; c++) begin
        sel_r[c] <= sel_nxt[c];
      end
      for (int i = 0; i < TAPS; i++) begin
        v3_r[i] <= taps[i];
      end
      out_valid_r <= s3_v_r;
      out_data_r  <= med;
      out_last_r  <= s3_last_r;
      out_fend_r  <= s3_fend_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_fend_r;

  `ASSERT_ALWAYS(a_fifo_bound, cnt_r <= FCW'(FD), "pending result count exceeds queue depth")
  `ASSERT_IMPLIES(a_pop_nonempty, pop, cnt_r != '0, "result queue popped while empty")
  `ASSERT_IMPLIES(a_fill_row_start, step_r != '0, have && (head.pos.ox == '0),
                  "window fill running for a result that is not at a row start")
  `ASSERT_ALWAYS(a_step_bound, step_r <= STW'(2 * R), "window fill step out of range")

endmodule

// File: sim/tb_median_window_filter_rgb.sv
// Self-checking testbench of the streaming RGB window median filter.
module tb_median_window_filter_rgb
  import mwf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       fend;
  } median_t;

  class median_scoreboard;
    logic [23:0] line_rows [0:4*1024-1];
    int unsigned width_reg, height_reg, col_pos, row_pos, out_pos;
    bit frame_done;
    median_t pending_q [$];
    int unsigned errors;

    function new();
      foreach (line_rows[i]) line_rows[i] = '0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      restart_frame();
      errors = 0;
    endfunction

    function void restart_frame();
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
      frame_done = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg < 1) ? 1 : height_reg;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      if (idx == CFG_IMAGE_WIDTH) width_reg = val[10:0];
      else height_reg = val;
      restart_frame();
    endfunction

    function bit output_ready();
      int unsigned w, h, oy, ox, ny, nx;
      w = eff_w();
      h = eff_h();
      if (out_pos >= w * h) return 0;
      if (frame_done) return 1;
      oy = out_pos / w;
      ox = out_pos % w;
      ny = (oy + 1 > h - 1) ? h - 1 : oy + 1;
      nx = (ox + 1 > w - 1) ? w - 1 : ox + 1;
      return ny * w + nx < row_pos * w + col_pos;
    endfunction

    function int unsigned backlog();
      if (!frame_done) return 0;
      return eff_w() * eff_h() - out_pos;
    endfunction

    function logic [7:0] median9(logic [7:0] v [9]);
      logic [7:0] t;
      for (int i = 1; i < 9; i++)
        for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
          t = v[j];
          v[j] = v[j-1];
          v[j-1] = t;
        end
      return v[4];
    endfunction

    function median_t compute_median();
      logic [7:0] r [9], g [9], b [9];
      logic [23:0] p;
      int w, h, oy, ox, yy, xx, k;
      median_t m;
      w = eff_w();
      h = eff_h();
      oy = out_pos / w;
      ox = out_pos % w;
      k = 0;
      for (int i = 0; i < 3; i++) begin
        yy = oy - 1 + i;
        if (yy < 0) yy = 0;
        if (yy > h - 1) yy = h - 1;
        for (int j = 0; j < 3; j++) begin
          xx = ox - 1 + j;
          if (xx < 0) xx = 0;
          if (xx > w - 1) xx = w - 1;
          p = line_rows[(yy % 4) * 1024 + xx];
          r[k] = p[7:0];
          g[k] = p[15:8];
          b[k] = p[23:16];
          k++;
        end
      end
      m.red = median9(r);
      m.green = median9(g);
      m.blue = median9(b);
      m.last = 0;
      m.fend = (out_pos == w * h - 1);
      out_pos++;
      return m;
    endfunction

    function void note_input(action_t act, logic [23:0] pix);
      median_t res [$];
      if (act == ACT_PIXEL) begin
        if (frame_done) begin
          out_pos = 0;
          frame_done = 0;
        end
        line_rows[(row_pos % 4) * 1024 + col_pos] = pix;
        col_pos++;
        if (col_pos >= eff_w()) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= eff_h()) begin
            row_pos = 0;
            frame_done = 1;
          end
        end
        while (res.size() < 2 && output_ready()) res.push_back(compute_median());
      end else if (output_ready()) begin
        res.push_back(compute_median());
      end
      if (res.size() > 0) res[res.size()-1].last = 1;
      foreach (res[i]) pending_q.push_back(res[i]);
    endfunction

    function void check_result(logic [23:0] data, logic last, logic fend);
      median_t e;
      median_t a;
      a = '{red: data[7:0], green: data[15:8], blue: data[23:16], last: last, fend: fend};
      if (pending_q.size() == 0) begin
        $display("%0t: expected no result, actual r=%h g=%h b=%h last=%b end=%b",
                 $time, a.red, a.green, a.blue, a.last, a.fend);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a !== e) begin
        $display("%0t: expected r=%h g=%h b=%h last=%b end=%b, actual r=%h g=%h b=%h last=%b end=%b",
                 $time, e.red, e.green, e.blue, e.last, e.fend,
                 a.red, a.green, a.blue, a.last, a.fend);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [23:0] out_tdata;
  logic out_tlast;
  logic [0:0] out_tuser;
  logic cfg_wr_en = 0;
  logic cfg_index = 0;
  logic [15:0] cfg_data = '0;

  median_scoreboard sb = new();
  bit no_idle = 0;
  int unsigned item_count = 0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  median_window_filter_rgb dut (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 300000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : int'($urandom_range(0, 4));
      if (stall > 0) begin
        out_tready = 0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tlast, out_tuser[0]);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(action_t act, logic [23:0] pix);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 4));
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = act;
    in_tdata = pix;
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, pix);
    item_count++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    wait_idle();
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_data = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic run_frame(bit drain_all);
    int unsigned n;
    n = sb.eff_w() * sb.eff_h();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(ACT_DRAIN, 24'($urandom));
      send_item(ACT_PIXEL, 24'($urandom));
    end
    n = drain_all ? sb.backlog() + $urandom_range(0, 2) : $urandom_range(0, sb.backlog());
    repeat (n) send_item(ACT_DRAIN, 24'($urandom));
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1;
    send_item(ACT_PIXEL, 24'h000000);
    send_item(ACT_PIXEL, 24'hFFFFFF);
    send_item(ACT_DRAIN, 24'h000000);
    write_reg(CFG_IMAGE_WIDTH, 16'd0);
    write_reg(CFG_IMAGE_HEIGHT, 16'd0);
    send_item(ACT_PIXEL, 24'hFFFFFF);
    send_item(ACT_DRAIN, 24'h000000);
    send_item(ACT_DRAIN, 24'h000000);
    write_reg(CFG_IMAGE_WIDTH, 16'd4);
    write_reg(CFG_IMAGE_HEIGHT, 16'd4);
    for (int i = 0; i < 16; i++) send_item(ACT_PIXEL, (i % 3 == 0) ? 24'hFFFFFF : 24'h000000);
    repeat (4) send_item(ACT_DRAIN, 24'hFFFFFF);
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    repeat (6) send_item(ACT_PIXEL, 24'($urandom));
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    repeat (5) send_item(ACT_PIXEL, 24'($urandom));
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    while (item_count < 1250) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(0, 12)));
        write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 8)));
      end
      run_frame($urandom_range(0, 3) != 0);
    end
    no_idle = 0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
